/* hdl/pulse_height_histogram_macros.svh */
// assertion macros used by the histogram top level
`ifndef PULSE_HEIGHT_HISTOGRAM_MACROS_SVH
`define PULSE_HEIGHT_HISTOGRAM_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PHH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PHH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PHH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PHH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/phh_pkg.sv */
package phh_pkg;

  localparam int LEVEL_W   = 14;
  localparam int CH_W      = 11;
  localparam int ACT_W     = 2;
  localparam int SEL_W     = 10;
  localparam int CNT_OUT_W = 32;
  localparam int OCC_OUT_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = CH_W + LEVEL_W;

  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 14'h2000;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 14'h1FFF;
  localparam logic [CH_W-1:0]    CHANNELS_RST  = 11'd1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_RECORD = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEVEL = 2'd0,
    REG_MAX_LEVEL = 2'd1,
    REG_CHANNELS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_FETCH,
    ST_UPDATE,
    ST_READ
  } state_e;

  function automatic logic [LEVEL_W-1:0] abs_diff(input logic signed [LEVEL_W-1:0] a,
                                                  input logic signed [LEVEL_W-1:0] b);
    logic signed [LEVEL_W:0] d;
    d = {a[LEVEL_W-1], a} - {b[LEVEL_W-1], b};
    abs_diff = d[LEVEL_W] ? LEVEL_W'(-d) : LEVEL_W'(d);
  endfunction

endpackage

/* hdl/pulse_height_histogram.sv */
// Pulse height histogram. One item is taken at a time: start is accepted while busy is low,
// and its single result appears on the result ports for exactly one cycle with done high.
// A record goes through a product stage and a one-bit-per-cycle divider followed by a
// read-modify-write of the spectrum memory; the divider is skipped when the bin clamps to
// the last channel, and a record is answered without entering the product stage when the
// range or channel count is zero. A read goes through the memory's registered port. The
// spectrum is zeroed by a pass that writes one bin per cycle over all MAX_CHANNELS bins after
// reset, after a clear item (whose result comes at the end of the pass) and after any register
// write that changes a value; busy stays high throughout, and such a write may drop an item
// still in flight without a result. Register writes are always ready. Results cannot be held off by the receiver.
`include "pulse_height_histogram_macros.svh"

module pulse_height_histogram #(
  parameter int MAX_CHANNELS = 1024,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [phh_pkg::ACT_W-1:0]            action_i,
  input  logic signed [phh_pkg::LEVEL_W-1:0]   background_i,
  input  logic signed [phh_pkg::LEVEL_W-1:0]   pulse_extreme_i,
  input  logic [phh_pkg::SEL_W-1:0]            bin_select_i,
  output logic                                 done_o,
  output logic                                 recorded_o,
  output logic [phh_pkg::SEL_W-1:0]            bin_index_o,
  output logic [phh_pkg::CNT_OUT_W-1:0]        bin_count_o,
  output logic [phh_pkg::OCC_OUT_W-1:0]        occupied_bins_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [phh_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [phh_pkg::LEVEL_W-1:0]          cfg_data_i
);

  import phh_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHANNELS);
  localparam int OCC_W = $clog2(MAX_CHANNELS + 1);
  localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(MAX_CHANNELS - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  state_e state_q, state_d;

  logic signed [LEVEL_W-1:0] min_q;
  logic signed [LEVEL_W-1:0] max_q;
  logic [CH_W-1:0]           chan_q;

  logic [LEVEL_W-1:0] range_q;
  logic [CH_W-1:0]    ch_q;
  logic [PROD_W-1:0]  fs_q;

  logic [LEVEL_W-1:0] amp_q;
  logic [SEL_W-1:0]   sel_q;
  logic [PROD_W-1:0]  num_q;
  logic [IDX_W-1:0]   bin_q;
  logic [IDX_W-1:0]   sweep_q;
  logic               clr_item_q;
  logic [OCC_W-1:0]   nonzero_q, nonzero_d;

  logic                 res_valid_q;
  logic                 res_rec_q;
  logic [SEL_W-1:0]     res_idx_q;
  logic [CNT_OUT_W-1:0] res_cnt_q;
  logic [OCC_OUT_W-1:0] res_occ_q;

  logic cfg_we;
  logic cfg_change;
  logic cfg_change_w;
  logic accept;
  logic sel_in_range;
  logic no_record;
  logic clamp;

  logic                   ram_rd_en;
  logic [IDX_W-1:0]       ram_rd_addr;
  logic [COUNT_WIDTH-1:0] ram_rd_data;
  logic                   ram_wr_en;
  logic [IDX_W-1:0]       ram_wr_addr;
  logic [COUNT_WIDTH-1:0] ram_wr_data;

  logic             div_start;
  logic             div_done;
  logic [IDX_W-1:0] div_quot;

  logic                   emit;
  logic                   e_rec;
  logic [SEL_W-1:0]       e_idx;
  logic [COUNT_WIDTH-1:0] e_cnt;

  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] inc_cnt;
  logic                   sat;

  // config write channel
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    case (cfg_reg_e'(cfg_index_i))
      REG_MIN_LEVEL: cfg_change = cfg_data_i != min_q;
      REG_MAX_LEVEL: cfg_change = cfg_data_i != max_q;
      REG_CHANNELS:  cfg_change = cfg_data_i[CH_W-1:0] != chan_q;
      default:       cfg_change = 1'b0;
    endcase
  end

  assign cfg_change_w = cfg_we & cfg_change;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MIN_LEVEL_RST;
      max_q  <= MAX_LEVEL_RST;
      chan_q <= CHANNELS_RST;
    end else if (cfg_change_w) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MIN_LEVEL: min_q  <= cfg_data_i;
        REG_MAX_LEVEL: max_q  <= cfg_data_i;
        REG_CHANNELS:  chan_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // derived scale terms, settle during the clearing pass that follows any change
  always_ff @(posedge clk_i) begin
    range_q <= abs_diff(max_q, min_q);
    ch_q    <= (32'(chan_q) > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) : chan_q;
    fs_q    <= PROD_W'(ch_q) * PROD_W'(range_q);
  end

  assign busy_o       = state_q != ST_IDLE;
  assign accept       = start_i & (state_q == ST_IDLE);
  assign sel_in_range = 32'(bin_select_i) < MAX_CHANNELS;
  assign no_record    = (range_q == '0) || (ch_q == '0);
  assign clamp        = num_q >= fs_q;

  assign cur_cnt = ram_rd_data;
  assign sat     = cur_cnt == COUNT_MAX;
  assign inc_cnt = cur_cnt + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_q == SWEEP_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (act_e'(action_i))
            ACT_RECORD: state_d = no_record ? ST_IDLE : ST_MUL;
            ACT_READ:   state_d = sel_in_range ? ST_READ : ST_IDLE;
            ACT_CLEAR:  state_d = ST_SWEEP;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL:    state_d = ST_CHECK;
      ST_CHECK:  state_d = clamp ? ST_FETCH : ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_FETCH;
      end
      ST_FETCH:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      ST_READ:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
    if (cfg_change_w) state_d = ST_SWEEP;
  end

  // outputs of the sequencer
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = bin_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = bin_q;
    ram_wr_data = inc_cnt;
    div_start   = 1'b0;
    emit        = 1'b0;
    e_rec       = 1'b0;
    e_idx       = '0;
    e_cnt       = '0;
    nonzero_d   = nonzero_q;
    case (state_q)
      ST_SWEEP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = sweep_q;
        ram_wr_data = '0;
        emit        = (sweep_q == SWEEP_LAST) && clr_item_q && !cfg_change_w;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (act_e'(action_i))
            ACT_RECORD: emit = no_record;
            ACT_READ: begin
              if (sel_in_range) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = IDX_W'(bin_select_i);
              end else begin
                emit  = 1'b1;
                e_idx = bin_select_i;
              end
            end
            ACT_CLEAR: nonzero_d = '0;
            default:   emit = 1'b1;
          endcase
        end
      end
      ST_CHECK: div_start = !clamp;
      ST_FETCH: ram_rd_en = 1'b1;
      ST_UPDATE: begin
        emit  = 1'b1;
        e_idx = SEL_W'(bin_q);
        e_cnt = sat ? cur_cnt : inc_cnt;
        if (!sat) begin
          ram_wr_en = 1'b1;
          e_rec     = 1'b1;
          if (cur_cnt == '0) nonzero_d = nonzero_q + 1'b1;
        end
      end
      ST_READ: begin
        emit  = 1'b1;
        e_idx = sel_q;
        e_cnt = ram_rd_data;
      end
      default: ;
    endcase
    if (cfg_change_w) nonzero_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      clr_item_q  <= 1'b0;
      nonzero_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nonzero_q   <= nonzero_d;
      res_valid_q <= emit;
      if (cfg_change_w) begin
        sweep_q    <= '0;
        clr_item_q <= 1'b0;
      end else if (accept && (action_i == ACT_CLEAR)) begin
        sweep_q    <= '0;
        clr_item_q <= 1'b1;
      end else if (state_q == ST_SWEEP) begin
        sweep_q <= sweep_q + 1'b1;
        if (sweep_q == SWEEP_LAST) clr_item_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      amp_q <= abs_diff(background_i, pulse_extreme_i);
      sel_q <= bin_select_i;
    end
    if (state_q == ST_MUL) begin
      num_q <= PROD_W'(ch_q) * PROD_W'(amp_q);
    end
    if (state_q == ST_CHECK && clamp) begin
      bin_q <= IDX_W'(ch_q - CH_W'(1));
    end else if (state_q == ST_DIV && div_done) begin
      bin_q <= div_quot;
    end
    if (emit) begin
      res_rec_q <= e_rec;
      res_idx_q <= e_idx;
      res_cnt_q <= CNT_OUT_W'(e_cnt);
      res_occ_q <= OCC_OUT_W'(nonzero_d);
    end
  end

  assign done_o          = res_valid_q;
  assign recorded_o      = res_rec_q;
  assign bin_index_o     = res_idx_q;
  assign bin_count_o     = res_cnt_q;
  assign occupied_bins_o = res_occ_q;

  phh_spectrum_ram #(
    .DEPTH(MAX_CHANNELS),
    .AW   (IDX_W),
    .DW   (COUNT_WIDTH)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data)
  );

  phh_bin_div #(
    .QW(IDX_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (range_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  `PHH_ASSERT_IMPLY(a_nonzero_bound, clk_i, rst_ni, 1'b1, 32'(nonzero_q) <= MAX_CHANNELS)
  `PHH_ASSERT_IMPLY(a_record_occupies, clk_i, rst_ni, emit && e_rec, nonzero_d != '0)
  `PHH_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy_o || done_o)
  `PHH_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, accept && (action_i == ACT_CLEAR), nonzero_q == '0)
  `PHH_ASSERT_IMPLY(a_ram_no_overlap, clk_i, rst_ni, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)

endmodule

/* hdl/phh_spectrum_ram.sv */
module phh_spectrum_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/phh_bin_div.sv */
module phh_bin_div #(
  parameter int QW = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [phh_pkg::PROD_W-1:0]  num_i,
  input  logic [phh_pkg::LEVEL_W-1:0] den_i,
  output logic                        done_o,
  output logic [QW-1:0]               quot_o
);

  import phh_pkg::*;

  // quotient is known to stay below 2^QW, so only QW compare steps
  localparam int DW = (PROD_W > LEVEL_W + QW) ? PROD_W : LEVEL_W + QW;
  localparam int CW = $clog2(QW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [QW-1:0] quot_q;
  logic          ge;

  assign ge = rem_q >= dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DW'(num_i);
      dvs_q  <= DW'(den_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_q - dvs_q : rem_q;
      dvs_q  <= dvs_q >> 1;
      quot_q <= (quot_q << 1) | QW'(ge);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
